// ===== design/base64_codec_unit_assert.svh =====
// Assertion macros shared by the codec checker.
`ifndef BASE64_CODEC_UNIT_ASSERT_SVH
`define BASE64_CODEC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define B64C_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define B64C_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/b64c_pkg.sv =====
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

  localparam logic [7:0] PadChar  = 8'h3D;  // '='
  localparam logic [7:0] PlusChar = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F; // '/'
  localparam logic [7:0] NoSextet = 8'h80;  // flag for a character outside the alphabet

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic        enc;     // encode group (four characters) vs decode group
    logic [23:0] bits;    // left-aligned group bits
    logic [1:0]  held;    // encode: bytes held, 1..3
    logic [1:0]  num_m1;  // number of results minus one
    logic        marker;  // decode: bare end marker, no data
    logic        last;    // item closed the stream
    logic        err;     // decode: partial group dropped
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = PlusChar;
    end else begin
      r = SlashChar;
    end
    return r;
  endfunction

  // Sextet value in the low six bits, or NoSextet.
  function automatic logic [7:0] char_sextet(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == PlusChar) begin
      r = 8'd62;
    end else if (c == SlashChar) begin
      r = 8'd63;
    end else if (c == PadChar) begin
      r = 8'd0;
    end else begin
      r = NoSextet;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64c_front.sv =====
// ----------------------------------------------------------------------------
// b64c_front
// Accepts items, keeps the partial group and issues jobs to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64c_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             item_valid_i,
  output logic                  item_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             in_last_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output b64c_pkg::job_t        job_o
);

  logic        dir_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  count_q, count_d;
  logic [1:0]  pad_q, pad_d;
  logic        accept;

  logic [7:0]  sext;
  logic [1:0]  held;
  logic        emit;

  assign item_ready_o = !q_full_i;
  assign accept       = item_valid_i && item_ready_o;
  assign sext         = b64c_pkg::char_sextet(in_byte_i);
  assign held         = count_q + 2'd1;

  always_comb begin
    bits_d  = bits_q;
    count_d = count_q;
    pad_d   = pad_q;
    emit    = 1'b0;
    job_o   = '0;
    if (dir_q == b64c_pkg::DirEncode) begin
      bits_d = {bits_q[15:0], in_byte_i};
      job_o.enc    = 1'b1;
      job_o.held   = held;
      job_o.num_m1 = 2'd3;
      job_o.last   = in_last_i;
      case (held)
        2'd1:    job_o.bits = {bits_d[7:0], 16'h0000};
        2'd2:    job_o.bits = {bits_d[15:0], 8'h00};
        default: job_o.bits = bits_d;
      endcase
      if (held == 2'd3 || in_last_i) begin
        emit    = 1'b1;
        bits_d  = '0;
        count_d = '0;
      end else begin
        count_d = held;
      end
    end else begin
      job_o.last = in_last_i;
      if (!sext[7]) begin
        if (in_byte_i == b64c_pkg::PadChar) begin
          if (count_q == 2'd2) pad_d[0] = 1'b1;
          if (count_q == 2'd3) pad_d[1] = 1'b1;
        end
        bits_d = {bits_q[17:0], sext[5:0]};
        if (count_q == 2'd3) begin
          emit       = 1'b1;
          job_o.bits = bits_d;
          job_o.num_m1 = pad_d[0] ? 2'd0 : (pad_d[1] ? 2'd1 : 2'd2);
          bits_d     = '0;
          count_d    = '0;
          pad_d      = '0;
        end else begin
          count_d = held;
        end
      end
      if (in_last_i) begin
        if (!emit) begin
          // nothing emitted: close the stream with a bare marker
          emit         = 1'b1;
          job_o.marker = 1'b1;
          job_o.num_m1 = 2'd0;
          job_o.err    = (count_d != 2'd0);
        end
        bits_d  = '0;
        count_d = '0;
        pad_d   = '0;
      end
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= b64c_pkg::DirEncode;
      bits_q  <= '0;
      count_q <= '0;
      pad_q   <= '0;
    end else if (cfg_we_i) begin
      dir_q   <= cfg_wdata_i;
      bits_q  <= '0;
      count_q <= '0;
      pad_q   <= '0;
    end else if (accept) begin
      bits_q  <= bits_d;
      count_q <= count_d;
      pad_q   <= pad_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64c_queue.sv =====
// ----------------------------------------------------------------------------
// b64c_queue
// Short job FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64c_queue #(
  parameter int Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b64c_pkg::job_t job_i,
  output logic                full_o,
  output logic                valid_o,
  output b64c_pkg::job_t      job_o,
  input  wire logic           pop_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64c_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b64c_back.sv =====
// ----------------------------------------------------------------------------
// b64c_back
// Expands one job into its results, one per cycle unless the result is stalled, into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64c_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire b64c_pkg::job_t q_job_i,
  output logic                q_pop_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_valid_o,
  output logic                run_end_o,
  output logic                stream_end_o,
  output logic                format_error_o
);

  b64c_pkg::job_t job_q;
  logic           busy_q;
  logic [1:0]     idx_q;
  logic           can_emit, job_done;

  logic       res_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       dval_q, dval_d;
  logic       run_q, strm_q, err_q, err_d;
  logic [5:0] sext;

  assign can_emit = busy_q && (!res_valid_q || res_ready_i);
  assign job_done = can_emit && (idx_q == job_q.num_m1);
  assign q_pop_o  = q_valid_i && (!busy_q || job_done);

  always_comb begin
    case (idx_q)
      2'd0:    sext = job_q.bits[23:18];
      2'd1:    sext = job_q.bits[17:12];
      2'd2:    sext = job_q.bits[11:6];
      default: sext = job_q.bits[5:0];
    endcase
    err_d = 1'b0;
    if (job_q.enc) begin
      byte_d = (idx_q <= job_q.held) ? b64c_pkg::sextet_char(sext) : b64c_pkg::PadChar;
      dval_d = 1'b1;
    end else if (job_q.marker) begin
      byte_d = 8'h00;
      dval_d = 1'b0;
      err_d  = job_q.err;
    end else begin
      case (idx_q)
        2'd0:    byte_d = job_q.bits[23:16];
        2'd1:    byte_d = job_q.bits[15:8];
        default: byte_d = job_q.bits[7:0];
      endcase
      dval_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (job_done) begin
      busy_q <= 1'b0;
    end else if (can_emit) begin
      idx_q  <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (can_emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_emit) begin
      byte_q <= byte_d;
      dval_q <= dval_d;
      run_q  <= job_done;
      strm_q <= job_done && job_q.last;
      err_q  <= err_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign out_byte_o     = byte_q;
  assign out_valid_o    = dval_q;
  assign run_end_o      = run_q;
  assign stream_end_o   = strm_q;
  assign format_error_o = err_q;

endmodule

`default_nettype wire

// ===== design/base64_codec_unit.sv =====
// ----------------------------------------------------------------------------
// base64_codec_unit
// Streaming base64 codec, standard alphabet with '=' padding.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  item in  | item_valid_i / item_ready_o | in_byte_i, in_last_i
//  result   | res_valid_o / res_ready_i   | out_byte_o, out_valid_o, run_end_o,
//           |                            | stream_end_o, format_error_o
//  config   | cfg_we_i                    | cfg_wdata_i (direction)
//
// Items are taken one per cycle while the job queue has room.
// Results leave one per cycle from the back end unless res_ready_i stalls:
// encoding gives 4 characters per 3 bytes, decoding up to 3 bytes per 4 chars.
// A closing item reaches the output via the queue and the job register.
// Reset clears the group state, queue pointers and result valid; no sweep.
// A stalled result register backs up the queue, then item_ready_o drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_codec_unit #(
  parameter int QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       item_valid_i,
  output logic            item_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic            run_end_o,
  output logic            stream_end_o,
  output logic            format_error_o
);

  b64c_pkg::job_t push_job, pop_job;
  logic           push, q_full, q_valid, pop;

  b64c_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid_i),
    .item_ready_o (item_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  b64c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (pop_job),
    .pop_i   (pop)
  );

  b64c_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_job_i        (pop_job),
    .q_pop_o        (pop),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .run_end_o      (run_end_o),
    .stream_end_o   (stream_end_o),
    .format_error_o (format_error_o)
  );

endmodule

`default_nettype wire

// ===== design/b64c_checker.sv =====
// ----------------------------------------------------------------------------
// b64c_checker
// Port-level checks on the codec's result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "base64_codec_unit_assert.svh"

module b64c_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid_o,
  input wire logic       res_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_valid_o,
  input wire logic       run_end_o,
  input wire logic       stream_end_o,
  input wire logic       format_error_o
);

  `B64C_ASSERT_NOW(a_stream_end_closes_run, clk_i, rst_ni, res_valid_o && stream_end_o, run_end_o, "stream end without run end")
  `B64C_ASSERT_NOW(a_error_on_marker, clk_i, rst_ni, res_valid_o && format_error_o, !out_valid_o && stream_end_o, "format error off an end marker")
  `B64C_ASSERT_NOW(a_marker_is_end, clk_i, rst_ni, res_valid_o && !out_valid_o, stream_end_o && out_byte_o == 8'h00, "bare marker not at stream end")
  `B64C_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, res_valid_o && !res_ready_i, res_valid_o && $stable(out_byte_o), "stalled result changed")

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_o    (res_valid_o),
  .res_ready_i    (res_ready_i),
  .out_byte_o     (out_byte_o),
  .out_valid_o    (out_valid_o),
  .run_end_o      (run_end_o),
  .stream_end_o   (stream_end_o),
  .format_error_o (format_error_o)
);

`default_nettype wire
